// ===== hw/rtl/lpat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpat_pkg
// Shared constants, codes and control types of the linear probe address table.
// ----------------------------------------------------------------------------
package lpat_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int OCC_W       = SLOT_W + 1;
   localparam int KEY_W       = 48;
   localparam int SIZE_W      = 48;
   localparam int HOME_SHIFT  = 12;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int MARK_W      = 2;

   localparam logic [OCC_W-1:0] HALF_DEPTH = OCC_W'(TABLE_DEPTH / 2);

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   typedef struct packed {
      logic start;
      logic read;
      logic check;
      logic finish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic probe_done;
      logic clear_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/linear_probe_address_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_address_table_unit
// Open-addressing table mapping an allocation address to its size, with
// linear probing from home slot (address >> 12) mod depth.
//
// req channel: insert or update, remove or lookup of one address per item.
// rsp channel: one item per request with status, slot and stored size.
// An item walks the probe path one slot at a time (slot memory read, then
// compare) until an empty slot, a hit or the whole table is seen; the next
// item is accepted only once the result of the last one has been written.
// After reset a clearing pass marks all 1024 slots empty, one per cycle;
// req_ready stays low until the pass is done.
// A result waits in the output register while rsp_ready is low; the next item
// may be accepted and probed meanwhile, and waits only at its own result.
// ----------------------------------------------------------------------------
module linear_probe_address_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lpat_pkg::REQ_W-1:0]     req_type,
   input  logic [lpat_pkg::KEY_W-1:0]     req_address,
   input  logic [lpat_pkg::SIZE_W-1:0]    req_entry_size,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpat_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lpat_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lpat_pkg::SIZE_W-1:0]    rsp_stored_size
);
   import lpat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lpat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpat_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_address     (req_address),
      .req_entry_size  (req_entry_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_stored_size (rsp_stored_size)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted item");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("result written while the output register is occupied");

   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished item did not show up on rsp");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ready)
      else $error("req_ready high during the clearing pass");

endmodule
`default_nettype wire

// ===== hw/rtl/lpat_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpat_datapath
// Slot memories, probe registers, occupancy count and result register.
// ----------------------------------------------------------------------------
module lpat_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lpat_pkg::cmd_type              cmd,
   output lpat_pkg::stat_type             stat,
   input  logic [lpat_pkg::REQ_W-1:0]     req_type,
   input  logic [lpat_pkg::KEY_W-1:0]     req_address,
   input  logic [lpat_pkg::SIZE_W-1:0]    req_entry_size,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpat_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lpat_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [lpat_pkg::SIZE_W-1:0]    rsp_stored_size
);
   import lpat_pkg::*;

   logic [KEY_W-1:0]  keys_mem  [TABLE_DEPTH];
   logic [SIZE_W-1:0] sizes_mem [TABLE_DEPTH];
   logic [MARK_W-1:0] marks_mem [TABLE_DEPTH];

   logic [REQ_W-1:0]  type_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] tomb_ff;
   logic              tomb_valid_ff;
   logic              hit_ff;
   logic              empty_ff;
   logic [SLOT_W-1:0] clr_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  occ_in;

   logic [KEY_W-1:0]  key_rd_ff;
   logic [SIZE_W-1:0] size_rd_ff;
   logic [MARK_W-1:0] mark_rd_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   logic is_empty;
   logic is_hit;
   logic is_tomb;

   // finish decision
   logic [STATUS_W-1:0] fin_status;
   logic [SLOT_W-1:0]   fin_slot;
   logic [SIZE_W-1:0]   fin_size;
   logic                fin_key_we;
   logic                fin_size_we;
   logic                fin_mark_we;
   logic [MARK_W-1:0]   fin_mark;

   logic                marks_we;
   logic [SLOT_W-1:0]   marks_addr;
   logic [MARK_W-1:0]   marks_data;

   assign is_empty = (mark_rd_ff == MARK_EMPTY);
   assign is_hit   = (mark_rd_ff == MARK_LIVE) && (key_rd_ff == key_ff);
   assign is_tomb  = !is_empty && (mark_rd_ff != MARK_LIVE);

   assign stat.probe_done = is_empty | is_hit | (&cnt_ff);
   assign stat.clear_last = &clr_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fin_status  = ST_NOTFOUND;
      fin_slot    = '0;
      fin_size    = '0;
      fin_key_we  = 1'b0;
      fin_size_we = 1'b0;
      fin_mark_we = 1'b0;
      fin_mark    = MARK_LIVE;
      occ_in      = occ_ff;
      case (type_ff)
         REQ_INSERT: begin
            if (hit_ff) begin
               fin_status  = ST_UPDATED;
               fin_slot    = idx_ff;
               fin_size    = size_ff;
               fin_size_we = 1'b1;
            end else if (occ_ff >= HALF_DEPTH) begin
               fin_status = ST_FULL;
            end else if (tomb_valid_ff || empty_ff) begin
               fin_status  = ST_INSERTED;
               fin_slot    = tomb_valid_ff ? tomb_ff : idx_ff;
               fin_size    = size_ff;
               fin_key_we  = 1'b1;
               fin_size_we = 1'b1;
               fin_mark_we = 1'b1;
               fin_mark    = MARK_LIVE;
               occ_in      = occ_ff + OCC_W'(1);
            end else begin
               fin_status = ST_FULL;
            end
         end
         REQ_REMOVE: begin
            if (hit_ff) begin
               fin_status  = ST_REMOVED;
               fin_slot    = idx_ff;
               fin_size    = size_rd_ff;
               fin_mark_we = 1'b1;
               fin_mark    = MARK_TOMB;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - OCC_W'(1);
               end
            end
         end
         default: begin
            if (hit_ff) begin
               fin_status = ST_FOUND;
               fin_slot   = idx_ff;
               fin_size   = size_rd_ff;
            end
         end
      endcase
   end

   assign marks_we   = cmd.clear | (cmd.finish & fin_mark_we);
   assign marks_addr = cmd.clear ? clr_ff : fin_slot;
   assign marks_data = cmd.clear ? MARK_EMPTY : fin_mark;

   // slot memories
   always_ff @(posedge clock) begin
      if (marks_we) begin
         marks_mem[marks_addr] <= marks_data;
      end
      if (cmd.finish && fin_key_we) begin
         keys_mem[fin_slot] <= key_ff;
      end
      if (cmd.finish && fin_size_we) begin
         sizes_mem[fin_slot] <= size_ff;
      end
      if (cmd.read) begin
         mark_rd_ff <= marks_mem[idx_ff];
         key_rd_ff  <= keys_mem[idx_ff];
         size_rd_ff <= sizes_mem[idx_ff];
      end
   end

   // probe registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         type_ff <= req_type;
         key_ff  <= req_address;
         size_ff <= req_entry_size;
         idx_ff  <= req_address[HOME_SHIFT +: SLOT_W];
         cnt_ff  <= '0;
      end else if (cmd.check && !stat.probe_done) begin
         idx_ff <= idx_ff + SLOT_W'(1);
         cnt_ff <= cnt_ff + SLOT_W'(1);
      end
      if (cmd.check && is_tomb && !tomb_valid_ff) begin
         tomb_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tomb_valid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         empty_ff      <= 1'b0;
         clr_ff        <= '0;
         occ_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            tomb_valid_ff <= 1'b0;
            hit_ff        <= 1'b0;
            empty_ff      <= 1'b0;
         end else if (cmd.check) begin
            hit_ff   <= is_hit;
            empty_ff <= is_empty;
            if (is_tomb) begin
               tomb_valid_ff <= 1'b1;
            end
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + SLOT_W'(1);
         end
         if (cmd.finish) begin
            occ_ff <= occ_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & !rsp_ready);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= fin_status;
         rsp_slot_ff   <= fin_slot;
         rsp_size_ff   <= fin_size;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_stored_size = rsp_size_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lpat_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpat_ctrl
// Sequencer for the clearing pass, the probe walk and the result write.
// ----------------------------------------------------------------------------
module lpat_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lpat_pkg::stat_type stat,
   output lpat_pkg::cmd_type  cmd
);
   import lpat_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.probe_done ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== dv/linear_probe_address_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_address_table_unit_test
// Self-checking bench for the linear probe address table. Requests go in over
// the req channel and results are checked field by field against a shadow
// table kept in the bench. The run covers directed corner cases, a long stall
// on the result side, random traffic on a clustered key set, and a final pass
// that leaves no empty slot so probes walk the whole table.
// ----------------------------------------------------------------------------
module linear_probe_address_table_unit_test;
   import lpat_pkg::*;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_ITEMS    = 100;
   localparam int POOL_KEYS       = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 32;

   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_W-1:0]   stored_size;
   } table_result_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type       = '0;
   logic [KEY_W-1:0]    req_address    = '0;
   logic [SIZE_W-1:0]   req_entry_size = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [SIZE_W-1:0]   rsp_stored_size;

   logic [KEY_W-1:0]  shadow_key  [TABLE_DEPTH];
   logic [SIZE_W-1:0] shadow_size [TABLE_DEPTH];
   logic [MARK_W-1:0] shadow_mark [TABLE_DEPTH];
   int                shadow_occupancy;
   table_result_type  pending_results[$];
   logic [KEY_W-1:0]  key_pool [POOL_KEYS];
   logic [KEY_W-1:0]  fill_key [TABLE_DEPTH];

   int error_count  = 0;
   int idle_cycles  = 0;
   bit send_idle_en = 1'b0;
   bit recv_idle_en = 1'b0;
   bit hold_off_req = 1'b0;

   linear_probe_address_table_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_address     (req_address),
      .req_entry_size  (req_entry_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_stored_size (rsp_stored_size)
   );

   always #(CLK_HALF) clock = ~clock;

   // shadow table: probe from the home slot, then apply the request
   function automatic table_result_type table_access(input logic [REQ_W-1:0] kind,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [SIZE_W-1:0] size);
      table_result_type res;
      int idx, visited, hit, tomb, dst;
      bit stop;
      res = '{ST_NOTFOUND, '0, '0};
      idx = int'(key[HOME_SHIFT +: SLOT_W]);
      visited = 0;
      hit = -1;
      tomb = -1;
      dst = -1;
      stop = 1'b0;
      while (!stop && visited < TABLE_DEPTH) begin
         if (shadow_mark[idx] == MARK_EMPTY) begin
            dst = idx;
            stop = 1'b1;
         end else if (shadow_mark[idx] == MARK_LIVE) begin
            if (shadow_key[idx] == key) begin
               hit = idx;
               stop = 1'b1;
            end
         end else if (tomb < 0) begin
            tomb = idx;
         end
         if (!stop) begin
            idx = (idx + 1) % TABLE_DEPTH;
            visited++;
         end
      end
      if (kind == REQ_INSERT) begin
         if (hit >= 0) begin
            shadow_size[hit] = size;
            res = '{ST_UPDATED, SLOT_W'(hit), size};
         end else if ((shadow_occupancy + 1) * 2 > TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            if (tomb >= 0) begin
               dst = tomb;
            end
            if (dst < 0) begin
               res.status = ST_FULL;
            end else begin
               shadow_key[dst]  = key;
               shadow_size[dst] = size;
               shadow_mark[dst] = MARK_LIVE;
               shadow_occupancy++;
               res = '{ST_INSERTED, SLOT_W'(dst), size};
            end
         end
      end else if (kind == REQ_REMOVE) begin
         if (hit >= 0) begin
            shadow_mark[hit] = MARK_TOMB;
            if (shadow_occupancy > 0) begin
               shadow_occupancy--;
            end
            res = '{ST_REMOVED, SLOT_W'(hit), shadow_size[hit]};
         end
      end else if (hit >= 0) begin
         res = '{ST_FOUND, SLOT_W'(hit), shadow_size[hit]};
      end
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin
            bits = '0;
         end
         1: begin
            bits = '1;
         end
         default: begin
         end
      endcase
      return bits[SIZE_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] key_at_home(input int home);
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      bits[HOME_SHIFT +: SLOT_W] = SLOT_W'(home);
      return bits[KEY_W-1:0];
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                               input logic [SIZE_W-1:0] size);
      @(negedge clock);
      if (send_idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_address    <= key;
      req_entry_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(table_access(kind, key, size));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_pool_item();
      logic [REQ_W-1:0] kind;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         kind = REQ_INSERT;
      end else if (pick < 65) begin
         kind = REQ_REMOVE;
      end else if (pick < 95) begin
         kind = REQ_LOOKUP;
      end else begin
         kind = REQ_SPARE;
      end
      send_request(kind, key_pool[$urandom_range(0, POOL_KEYS - 1)], random_size());
   endtask

   task automatic send_noise_item();
      logic [REQ_W-1:0] kind;
      logic [63:0]      bits;
      kind = REQ_W'($urandom_range(0, 3));
      // keep stray inserts rare so tombstones stay out of the way
      if (kind == REQ_INSERT && $urandom_range(0, 3) != 0) begin
         kind = REQ_LOOKUP;
      end
      bits = {$urandom, $urandom};
      send_request(kind, bits[KEY_W-1:0], random_size());
   endtask

   task automatic test_directed_corners();
      logic [KEY_W-1:0] top_key, wrap_key, wrap_key2;
      top_key   = '1;
      wrap_key  = key_at_home(TABLE_DEPTH - 1);
      wrap_key2 = key_at_home(TABLE_DEPTH - 1);
      send_request(REQ_LOOKUP, '0, '1);
      send_request(REQ_INSERT, '0, '1);
      send_request(REQ_LOOKUP, '0, '0);
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_INSERT, top_key, 48'h5555_5555_5555);
      // same home as the top key, wraps around to the start of the table
      send_request(REQ_INSERT, wrap_key, 48'hAAAA_AAAA_AAAA);
      send_request(REQ_SPARE, wrap_key, '0);
      send_request(REQ_REMOVE, top_key, '1);
      send_request(REQ_LOOKUP, wrap_key, '0);
      send_request(REQ_LOOKUP, top_key, '0);
      send_request(REQ_REMOVE, top_key, '0);
      send_request(REQ_INSERT, wrap_key2, random_size());
      send_request(REQ_INSERT, 48'd1, '1);
      send_request(REQ_REMOVE, '0, random_size());
      send_request(REQ_LOOKUP, 48'd1, '0);
      send_request(REQ_INSERT, '0, 48'h8000_0000_0001);
      send_request(REQ_REMOVE, wrap_key2, '0);
      send_request(REQ_SPARE, '0, '1);
      wait_drained();
   endtask

   task automatic test_output_stall();
      int n;
      hold_off_req = 1'b1;
      for (n = 0; n < 12; n++) begin
         send_pool_item();
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) begin
            send_idle_en = ($urandom_range(0, 2) != 0);
            recv_idle_en = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 99) < 85) begin
            send_pool_item();
         end else begin
            send_noise_item();
         end
      end
      wait_drained();
   endtask

   // half the table live, the other half tombstones: no empty slot remains
   task automatic test_table_saturation();
      logic [KEY_W-1:0] live_keys[$];
      logic [KEY_W-1:0] extra_key;
      int i;
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (shadow_mark[i] == MARK_LIVE) begin
            live_keys.push_back(shadow_key[i]);
         end
      end
      foreach (live_keys[j]) begin
         send_request(REQ_REMOVE, live_keys[j], random_size());
      end
      for (i = 0; i < TABLE_DEPTH; i++) begin
         fill_key[i] = key_at_home(i);
      end
      for (i = 0; i < TABLE_DEPTH / 2; i++) begin
         send_request(REQ_INSERT, fill_key[i], random_size());
      end
      for (i = 0; i < TABLE_DEPTH / 2; i++) begin
         send_request(REQ_REMOVE, fill_key[i], random_size());
      end
      for (i = TABLE_DEPTH / 2; i < TABLE_DEPTH; i++) begin
         send_request(REQ_INSERT, fill_key[i], random_size());
      end
      extra_key = key_at_home(3 * TABLE_DEPTH / 4);
      send_request(REQ_INSERT, extra_key, random_size());
      send_request(REQ_INSERT, fill_key[5 * TABLE_DEPTH / 8], '1);
      send_request(REQ_LOOKUP, key_at_home(TABLE_DEPTH / 4), '0);
      send_request(REQ_REMOVE, fill_key[5 * TABLE_DEPTH / 8], '0);
      send_request(REQ_INSERT, extra_key, random_size());
      send_request(REQ_LOOKUP, extra_key, '0);
      send_request(REQ_SPARE, fill_key[TABLE_DEPTH - 1], random_size());
      wait_drained();
   endtask

   initial begin : result_sink
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      table_result_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d slot %0d stored_size %0h",
                   rsp_status, rsp_slot, rsp_stored_size);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_slot);
               error_count++;
            end
            if (rsp_stored_size !== want.stored_size) begin
               $error("stored_size: expected %0h, actual %0h",
                      want.stored_size, rsp_stored_size);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         shadow_mark[i] = MARK_EMPTY;
      end
      shadow_occupancy = 0;
      // clustered keys around the top of the table so probes wrap
      for (i = 0; i < POOL_KEYS; i++) begin
         key_pool[i] = key_at_home((TABLE_DEPTH - 8 + $urandom_range(0, 15)) % TABLE_DEPTH);
      end
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_output_stall();
      test_random_traffic();
      test_table_saturation();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lpat_pkg.sv
hw/rtl/lpat_datapath.sv
hw/rtl/lpat_ctrl.sv
hw/rtl/linear_probe_address_table_unit.sv
dv/linear_probe_address_table_unit_test.sv
